### hdl/mrf_pkg.sv
// ---------------------------------------------------------------------------
// Message ring FIFO package
// Sizes, status codes and the command and status bundles that pass between
// the controller and the datapath.
// ---------------------------------------------------------------------------
package mrf_pkg;

   // Ring and message geometry.
   localparam int SLOTS     = 16;
   localparam int MSG_BYTES = 64;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int IDX_W     = $clog2(MSG_BYTES);
   localparam int LEN_W     = $clog2(MSG_BYTES + 1);
   localparam int ADDR_W    = SLOT_W + IDX_W;
   localparam int CNT_W     = SLOT_W;
   localparam int NSL_W     = SLOT_W + 1;

   // Slot count register limits.
   localparam logic [NSL_W-1:0] MIN_SLOTS   = NSL_W'(2);
   localparam logic [NSL_W-1:0] MAX_SLOTS   = NSL_W'(SLOTS);
   localparam logic [NSL_W-1:0] RESET_SLOTS = NSL_W'(16);
   localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MSG_BYTES);

   // Request operation codes.
   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_GET_BYTE  = 2'd0,
      ST_PUT_DONE  = 2'd1,
      ST_PUT_DROP  = 2'd2,
      ST_GET_EMPTY = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic put;        // a put word was accepted
      logic get_start;  // a get word was accepted
      logic get_next;   // a get byte was taken and more follow
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;      // no message is held
      logic get_last;   // the byte on the response port ends the message
   } stat_type;

endpackage

### hdl/mrf_ctrl.sv
// ---------------------------------------------------------------------------
// Message ring FIFO controller
// Sequences puts, empty gets and byte streaming of gets, and drives the
// request and response handshakes.
// ---------------------------------------------------------------------------
module mrf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrf_pkg::cmd_type  cmd,
   input  mrf_pkg::stat_type stat
);
   import mrf_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RESP,
      S_STREAM
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire, rsp_fire;

   // Handshakes.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_STREAM);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Commands to the datapath.
   always_comb begin
      cmd.put       = req_fire && (req_op == OP_PUT);
      cmd.get_start = req_fire && (req_op == OP_GET);
      cmd.get_next  = rsp_fire && (state_ff == S_STREAM) && !stat.get_last;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.put && req_last) begin
               state_in = S_RESP;
            end else if (cmd.get_start) begin
               state_in = stat.empty ? S_RESP : S_STREAM;
            end
         end
         S_RESP: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         S_STREAM: begin
            if (rsp_fire && stat.get_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mrf_datapath.sv
// ---------------------------------------------------------------------------
// Message ring FIFO datapath
// Holds the ring pointers, the payload, type and length stores and the
// response register.
// ---------------------------------------------------------------------------
module mrf_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_fire,
   input  logic [4:0]       csr_slots_in_use,
   input  logic [7:0]       req_data_byte,
   input  logic [7:0]       req_msg_type,
   input  logic             req_last,
   input  mrf_pkg::cmd_type  cmd,
   output mrf_pkg::stat_type stat,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_byte,
   output logic [7:0]       rsp_out_type,
   output logic [6:0]       rsp_out_length,
   output logic             rsp_last_byte,
   output logic [3:0]       rsp_entries
);
   import mrf_pkg::*;

   // Stores.
   logic [7:0]       payload_mem [2**ADDR_W];
   logic [7:0]       type_mem    [SLOTS];
   logic [LEN_W-1:0] length_mem  [SLOTS];

   // Queue state.
   logic [NSL_W-1:0]  nslots_ff, nslots_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              drop_ff, drop_in;

   // Response and streaming state.
   status_type        status_ff, status_in;
   logic [7:0]        type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  entries_ff, entries_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        rd_data_ff;

   // Intermediate values.
   logic [NSL_W-1:0]  csr_clamped;
   logic [SLOT_W-1:0] wslot_next, rslot_next;
   logic              full, drop_now, store_byte, commit, rd_en;
   logic [LEN_W-1:0]  fill_next, stored_len;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [IDX_W-1:0]  idx_next;

   // Clamp the slot count to the supported range.
   always_comb begin
      if (csr_slots_in_use < MIN_SLOTS) begin
         csr_clamped = MIN_SLOTS;
      end else if (csr_slots_in_use > MAX_SLOTS) begin
         csr_clamped = MAX_SLOTS;
      end else begin
         csr_clamped = csr_slots_in_use;
      end
   end

   // Ring pointer increments wrap at the active slot count.
   assign wslot_next = ({1'b0, wslot_ff} + NSL_W'(1) == nslots_ff) ?
                       '0 : wslot_ff + SLOT_W'(1);
   assign rslot_next = ({1'b0, rslot_ff} + NSL_W'(1) == nslots_ff) ?
                       '0 : rslot_ff + SLOT_W'(1);
   assign full       = (wslot_next == rslot_ff);

   // The drop decision is made on the first byte of a message.
   assign drop_now   = drop_ff || ((fill_ff == '0) && full);
   assign store_byte = cmd.put && !drop_now && (fill_ff < MAX_LEN);
   assign fill_next  = store_byte ? fill_ff + LEN_W'(1) : fill_ff;
   assign commit     = cmd.put && req_last && !drop_now;

   // Stored length, kept within one to the message size.
   always_comb begin
      stored_len = length_mem[rslot_ff];
      if (stored_len > MAX_LEN) stored_len = MAX_LEN;
      if (stored_len == '0) stored_len = LEN_W'(1);
   end

   // Payload read port: first byte on a get, following bytes as taken.
   assign idx_next = idx_ff + IDX_W'(1);
   assign rd_en    = (cmd.get_start && (count_ff != '0)) || cmd.get_next;
   assign rd_addr  = cmd.get_start ? {rslot_ff, {IDX_W{1'b0}}} : {cur_slot_ff, idx_next};
   assign wr_addr  = {wslot_ff, fill_ff[IDX_W-1:0]};

   // Queue state update; a configuration write empties the queue.
   always_comb begin
      nslots_in = nslots_ff;
      wslot_in  = wslot_ff;
      rslot_in  = rslot_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      drop_in   = drop_ff;
      if (csr_fire) begin
         nslots_in = csr_clamped;
         wslot_in  = '0;
         rslot_in  = '0;
         count_in  = '0;
         fill_in   = '0;
         drop_in   = 1'b0;
      end else if (cmd.put) begin
         if (req_last) begin
            fill_in = '0;
            drop_in = 1'b0;
            if (!drop_now) begin
               wslot_in = wslot_next;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            fill_in = fill_next;
            drop_in = drop_now;
         end
      end else if (cmd.get_start && (count_ff != '0)) begin
         rslot_in = rslot_next;
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Response register update.
   always_comb begin
      status_in   = status_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      entries_in  = entries_ff;
      cur_slot_in = cur_slot_ff;
      idx_in      = idx_ff;
      if (cmd.put && req_last) begin
         if (drop_now) begin
            status_in  = ST_PUT_DROP;
            type_in    = '0;
            len_in     = '0;
            entries_in = count_ff;
         end else begin
            status_in  = ST_PUT_DONE;
            type_in    = req_msg_type;
            len_in     = fill_next;
            entries_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.get_start) begin
         if (count_ff == '0) begin
            status_in  = ST_GET_EMPTY;
            type_in    = '0;
            len_in     = '0;
            entries_in = count_ff;
         end else begin
            status_in   = ST_GET_BYTE;
            type_in     = type_mem[rslot_ff];
            len_in      = stored_len;
            entries_in  = count_ff - CNT_W'(1);
            cur_slot_in = rslot_ff;
            idx_in      = '0;
         end
      end else if (cmd.get_next) begin
         idx_in = idx_next;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nslots_ff <= RESET_SLOTS;
         wslot_ff  <= '0;
         rslot_ff  <= '0;
         count_ff  <= '0;
         fill_ff   <= '0;
         drop_ff   <= 1'b0;
      end else begin
         nslots_ff <= nslots_in;
         wslot_ff  <= wslot_in;
         rslot_ff  <= rslot_in;
         count_ff  <= count_in;
         fill_ff   <= fill_in;
         drop_ff   <= drop_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      type_ff     <= type_in;
      len_ff      <= len_in;
      entries_ff  <= entries_in;
      cur_slot_ff <= cur_slot_in;
      idx_ff      <= idx_in;
   end

   // Payload memory with registered read.
   always_ff @(posedge clock) begin
      if (store_byte) payload_mem[wr_addr] <= req_data_byte;
      if (rd_en) rd_data_ff <= payload_mem[rd_addr];
   end

   // Type and length stores, written on commit.
   always_ff @(posedge clock) begin
      if (commit) begin
         type_mem[wslot_ff]   <= req_msg_type;
         length_mem[wslot_ff] <= fill_next;
      end
   end

   // Status to the controller.
   always_comb begin
      stat.empty    = (count_ff == '0);
      stat.get_last = ({1'b0, idx_ff} + LEN_W'(1) == len_ff);
   end

   // Response fields.
   assign rsp_status     = status_ff;
   assign rsp_out_byte   = (status_ff == ST_GET_BYTE) ? rd_data_ff : 8'd0;
   assign rsp_out_type   = type_ff;
   assign rsp_out_length = len_ff;
   assign rsp_last_byte  = (status_ff != ST_GET_BYTE) || stat.get_last;
   assign rsp_entries    = entries_ff;

endmodule

### hdl/message_ring_fifo_top.sv
// A put word that ends a message gives its status word in the next cycle.
// A get gives its first byte in the next cycle, then one byte a cycle
// while rsp_ready is high, paced by the registered payload memory read port.
// Throughput: one put word per cycle with no result pending; a get holds the
// request side until the last word of its response is taken. Reset clears
// pointers and counts at once; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
// Message ring FIFO top level
// Ring queue of typed messages with a controller and a datapath.
// ---------------------------------------------------------------------------
module message_ring_fifo_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_slots_in_use,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_msg_type,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_out_type,
   output logic [6:0] rsp_out_length,
   output logic       rsp_last_byte,
   output logic [3:0] rsp_entries
);
   import mrf_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_fire;

   // Configuration words are taken at any time.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   mrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mrf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_fire         (csr_fire),
      .csr_slots_in_use (csr_slots_in_use),
      .req_data_byte    (req_data_byte),
      .req_msg_type     (req_msg_type),
      .req_last         (req_last),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_length   (rsp_out_length),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_entries      (rsp_entries)
   );

endmodule
